@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

@@ hw/rtl/rgsd_pkg.sv @@
// ----------------------------------------------------------------------------
// Glyph span decoder package
// Sizes, register indexes and decode phase codes of the span decoder.
// ----------------------------------------------------------------------------
package rgsd_pkg;

  localparam int unsigned MaxGlyphDim = 64;
  localparam int unsigned ColW        = $clog2(MaxGlyphDim);
  localparam int unsigned DimW        = $clog2(MaxGlyphDim + 1);
  localparam int unsigned TotW        = $clog2(MaxGlyphDim * MaxGlyphDim + 1);
  localparam int unsigned RowW        = 7;
  localparam int unsigned CfgDimW     = 7;
  localparam int unsigned CoordW      = 16;
  localparam int unsigned CovW        = 8;
  localparam int unsigned LenW        = 7;
  localparam int unsigned DataW       = 32;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned SpanDataW   = 48;
  localparam int unsigned MaxSpans    = 64;
  localparam int unsigned SpanCntW    = $clog2(MaxSpans + 1);

  localparam logic [CoordW-1:0] OriginLim = CoordW'(65536 - MaxGlyphDim);
  localparam logic [8:0]        LitBase   = 9'h100;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GLYPH_WIDTH   = 3'd0,
    CFG_GLYPH_HEIGHT  = 3'd1,
    CFG_ORIGIN_X      = 3'd2,
    CFG_ORIGIN_Y      = 3'd3,
    CFG_SCREEN_WIDTH  = 3'd4,
    CFG_SCREEN_HEIGHT = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2,
    PH_DONE    = 2'd3
  } phase_e;

endpackage

@@ hw/rtl/rle_glyph_span_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// Run-length glyph span decoder
// Turns a run-length coded glyph word stream into clipped horizontal spans.
// ----------------------------------------------------------------------------
// Each input transaction carries one stream word; tuser marks the first word
// of a glyph. A header word is decoded in ST_IDLE, which stays ready. A
// pixel word is split into row segments by one shared segment unit
// (room-in-row minimum, screen position add and clip compare), one segment
// per cycle unless the output side stalls, each in its own glyph row; the
// next word is taken only once the word has left ST_FLUSH. A visible
// segment is parked in a pending register so the final span of each word
// can be flagged with tlast; an output register decouples the span stream
// from the decoder, so the next word is taken while the last span still
// waits. Configuration is a direct register write, taken any cycle.
`include "assert_macros.svh"

module rle_glyph_span_decoder_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [rgsd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rgsd_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // input word stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [rgsd_pkg::DataW-1:0]       s_axis_tdata_i,  // [31:0] data_word
  input  logic                             s_axis_tuser_i,  // [0] glyph_start
  // span stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [15:0] span_x, [31:16] span_y, [38:32] span_length, [46:39] coverage
  output logic [rgsd_pkg::SpanDataW-1:0]   m_axis_tdata_o,
  output logic                             m_axis_tlast_o   // last_of_run
);
  import rgsd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_e;

  // configuration registers
  logic [CfgDimW-1:0] glyph_width_q, glyph_height_q;
  logic [CoordW-1:0]  origin_x_q, origin_y_q, screen_width_q, screen_height_q;

  // decoder state
  state_e             state_q;
  phase_e             phase_q;
  logic [15:0]        rem_q;
  logic [ColW-1:0]    col_q;
  logic [RowW-1:0]    row_q;
  logic [TotW-1:0]    pd_q;
  logic [TotW-1:0]    count_q;
  logic [CovW-1:0]    cov_q;
  logic [SpanCntW-1:0] n_q;

  // pending span and output register
  logic               pend_valid_q;
  logic [CoordW-1:0]  pend_x_q, pend_y_q;
  logic [LenW-1:0]    pend_len_q;
  logic               out_valid_q, out_last_q;
  logic [CoordW-1:0]  out_x_q, out_y_q;
  logic [LenW-1:0]    out_len_q;
  logic [CovW-1:0]    out_cov_q;

  // clamped geometry
  logic [DimW-1:0]    w, h;
  logic [TotW-1:0]    total;
  logic [CoordW-1:0]  ox_c, oy_c;

  always_comb begin
    if (glyph_width_q == '0) begin
      w = DimW'(1);
    end else if (DimW'(glyph_width_q) > DimW'(MaxGlyphDim)) begin
      w = DimW'(MaxGlyphDim);
    end else begin
      w = DimW'(glyph_width_q);
    end
    if (glyph_height_q == '0) begin
      h = DimW'(1);
    end else if (DimW'(glyph_height_q) > DimW'(MaxGlyphDim)) begin
      h = DimW'(MaxGlyphDim);
    end else begin
      h = DimW'(glyph_height_q);
    end
  end

  assign total = TotW'(w) * TotW'(h);
  assign ox_c  = (origin_x_q > OriginLim) ? OriginLim : origin_x_q;
  assign oy_c  = (origin_y_q > OriginLim) ? OriginLim : origin_y_q;

  // --- word intake: glyph start clear, end check, row wrap, phase decode ---
  logic [DataW-1:0]   word;
  logic               start;
  phase_e             ph0;
  logic [15:0]        rem0, rem_dec;
  logic [ColW-1:0]    col0;
  logic [RowW-1:0]    row0;
  logic [TotW-1:0]    pd0, left, rep_count;
  logic               done0, wrap0, lit_hdr, accept;

  assign word    = s_axis_tdata_i;
  assign start   = s_axis_tuser_i;
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign ph0     = start ? PH_HEADER : phase_q;
  assign rem0    = start ? '0 : rem_q;
  assign col0    = start ? '0 : col_q;
  assign row0    = start ? '0 : row_q;
  assign pd0     = start ? '0 : pd_q;
  assign done0   = (ph0 == PH_DONE) || (pd0 >= total);
  assign wrap0   = DimW'(col0) >= w;
  assign left    = total - pd0;
  assign lit_hdr = &word[DataW-1:8];
  assign rem_dec = (rem0 != '0) ? rem0 - 16'd1 : '0;
  assign rep_count = (rem0 < 16'(left)) ? TotW'(rem0) : left;

  // --- shared segment unit: one run segment per cycle unless stalled ---
  logic [DimW-1:0]    room, seg, col_sum;
  logic [CoordW-1:0]  seg_x, span_room;
  logic [CoordW:0]    seg_y;
  logic [LenW-1:0]    seg_len;
  logic               visible, seg_wrap, out_free, stall;

  assign room      = w - DimW'(col_q);
  assign seg       = (count_q < TotW'(room)) ? DimW'(count_q) : room;
  assign seg_x     = ox_c + CoordW'(col_q);
  assign seg_y     = {1'b0, oy_c} + (CoordW + 1)'(row_q);
  assign span_room = screen_width_q - seg_x;
  assign seg_len   = (span_room < CoordW'(seg)) ? LenW'(span_room) : LenW'(seg);
  assign visible   = (cov_q != '0) && (seg_x < screen_width_q) &&
                     (seg_y < {1'b0, screen_height_q}) && (n_q < SpanCntW'(MaxSpans));
  assign col_sum   = DimW'(col_q) + seg;
  assign seg_wrap  = col_sum >= w;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  // hold the segment when a new span needs the pending slot and output is full
  assign stall     = visible && pend_valid_q && !out_free;

  // --- output push ---
  logic               push, push_last;

  always_comb begin
    push      = 1'b0;
    push_last = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        push = visible && pend_valid_q && out_free;
      end
      ST_FLUSH: begin
        push      = pend_valid_q && out_free;
        push_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // --- configuration registers ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_width_q   <= CfgDimW'(8);
      glyph_height_q  <= CfgDimW'(16);
      origin_x_q      <= '0;
      origin_y_q      <= '0;
      screen_width_q  <= CoordW'(800);
      screen_height_q <= CoordW'(600);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GLYPH_WIDTH:   glyph_width_q   <= cfg_wdata_i[CfgDimW-1:0];
        CFG_GLYPH_HEIGHT:  glyph_height_q  <= cfg_wdata_i[CfgDimW-1:0];
        CFG_ORIGIN_X:      origin_x_q      <= cfg_wdata_i;
        CFG_ORIGIN_Y:      origin_y_q      <= cfg_wdata_i;
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata_i;
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // --- sequencer, pending span and output register ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_HEADER;
      rem_q        <= '0;
      col_q        <= '0;
      row_q        <= '0;
      pd_q         <= '0;
      count_q      <= '0;
      cov_q        <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      pend_x_q     <= '0;
      pend_y_q     <= '0;
      pend_len_q   <= '0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_x_q      <= '0;
      out_y_q      <= '0;
      out_len_q    <= '0;
      out_cov_q    <= '0;
    end else begin
      // output register: load on push, drop once taken
      if (push) begin
        out_valid_q <= 1'b1;
        out_last_q  <= push_last;
        out_x_q     <= pend_x_q;
        out_y_q     <= pend_y_q;
        out_len_q   <= pend_len_q;
        out_cov_q   <= cov_q;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            pd_q  <= pd0;
            n_q   <= '0;
            cov_q <= word[CovW-1:0];
            if (done0) begin
              rem_q   <= rem0;
              col_q   <= col0;
              row_q   <= row0;
              phase_q <= PH_DONE;
            end else begin
              col_q <= wrap0 ? '0 : col0;
              row_q <= wrap0 ? row0 + RowW'(1) : row0;
              unique case (ph0)
                PH_HEADER: begin
                  if (lit_hdr) begin
                    rem_q   <= 16'(LitBase - {1'b0, word[7:0]});
                    phase_q <= PH_LITERAL;
                  end else begin
                    rem_q   <= word[15:0];
                    phase_q <= PH_REPEAT;
                  end
                end
                PH_LITERAL: begin
                  count_q <= TotW'(1);
                  rem_q   <= rem_dec;
                  phase_q <= (rem_dec == '0) ? PH_HEADER : PH_LITERAL;
                  state_q <= ST_RUN;
                end
                PH_REPEAT: begin
                  count_q <= rep_count;
                  rem_q   <= '0;
                  phase_q <= PH_HEADER;
                  // a zero-length repeat consumes the word and gives nothing
                  state_q <= (rep_count == '0) ? ST_FLUSH : ST_RUN;
                end
                default: begin
                  rem_q <= rem0;
                end
              endcase
            end
          end
        end

        ST_RUN: begin
          if (!stall) begin
            count_q <= count_q - TotW'(seg);
            pd_q    <= pd_q + TotW'(seg);
            col_q   <= seg_wrap ? '0 : col_sum[ColW-1:0];
            row_q   <= seg_wrap ? row_q + RowW'(1) : row_q;
            if (visible) begin
              pend_valid_q <= 1'b1;
              pend_x_q     <= seg_x;
              pend_y_q     <= seg_y[CoordW-1:0];
              pend_len_q   <= seg_len;
              n_q          <= n_q + SpanCntW'(1);
            end
            if (count_q == TotW'(seg)) begin
              state_q <= ST_FLUSH;
            end
          end
        end

        ST_FLUSH: begin
          // release the final span of this word with tlast, then finish
          if (!pend_valid_q || out_free) begin
            pend_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
            if (pd_q >= total) begin
              phase_q <= PH_DONE;
            end
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {1'b0, out_cov_q, out_len_q, out_y_q, out_x_q};

  // --- assertions ---
  `ASSERT_PROP(a_idle_no_pending, clk_i, rst_ni, s_axis_tready_o |-> !pend_valid_q)
  `ASSERT_PROP(a_run_has_pixels, clk_i, rst_ni, (state_q == ST_RUN) |-> (count_q != '0))
  `ASSERT_PROP(a_span_cap, clk_i, rst_ni, n_q <= SpanCntW'(MaxSpans))
  `ASSERT_PROP(a_stall_output_full, clk_i, rst_ni, (state_q == ST_RUN && stall) |-> out_valid_q)
  `ASSERT_NEVER(a_empty_span, clk_i, rst_ni, out_valid_q && (out_len_q == '0 || out_cov_q == '0))

endmodule

@@ tb/sv/rle_glyph_span_decoder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Glyph span decoder testbench
// Drives coded glyph word streams into the span decoder and checks every span
// it emits, field by field, against a cycle-free behavioral predictor kept in
// this file. Directed streams cover header kinds, clipping, origin saturation,
// size clamping, runs cut at the glyph end, ignored trailing words and resizing
// in the middle of a glyph; random glyph streams follow under three idling
// mixes, plus a long output stall that backs the decoder up.
// ----------------------------------------------------------------------------
module rle_glyph_span_decoder_unit_tb;
  import rgsd_pkg::*;

  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned ResetCycles   = 5;
  // An invisible repeat run keeps the decoder busy without a span, one segment
  // per glyph row it touches, so wait SettleCycles before touching a register.
  localparam int unsigned SettleCycles  = 100;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned CycleLimit    = 2_000_000;
  localparam int unsigned MaxReports    = 10;

  // One span as the decoder reports it.
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [LenW-1:0]   len;
    logic [CovW-1:0]   cov;
    logic              last;
  } span_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input holds a known value from time zero
  // --------------------------------------------------------------------------
  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i     = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i     = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [DataW-1:0]     s_axis_tdata_i  = '0;  // [31:0] data_word
  logic                 s_axis_tuser_i  = 1'b0;  // [0] glyph_start
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  // [15:0] span_x, [31:16] span_y, [38:32] span_length, [46:39] coverage
  logic [SpanDataW-1:0] m_axis_tdata_o;
  logic                 m_axis_tlast_o;   // last_of_run

  rle_glyph_span_decoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Span predictor: its own copy of the registers and the decode state
  // --------------------------------------------------------------------------
  logic [CfgDimW-1:0] glyph_w_reg = 7'd8;
  logic [CfgDimW-1:0] glyph_h_reg = 7'd16;
  logic [CoordW-1:0]  org_x_reg   = 16'd0;
  logic [CoordW-1:0]  org_y_reg   = 16'd0;
  logic [CoordW-1:0]  scr_w_reg   = 16'd800;
  logic [CoordW-1:0]  scr_h_reg   = 16'd600;

  phase_e             phase       = PH_HEADER;
  logic [15:0]        block_left  = '0;   // literal pixels or repeat count due
  int unsigned        column      = 0;
  logic [RowW-1:0]    row         = '0;
  int unsigned        pixels_done = 0;

  span_t              expected_spans[$];
  int unsigned        words_decoded = 0;  // words that were not ignored
  int unsigned        mismatches    = 0;

  // Idling mix, in percent of cycles, and the long output stall request.
  int unsigned        tx_idle_pct = 25;
  int unsigned        rx_idle_pct = 82;
  int unsigned        holdoff_requests = 0;
  int unsigned        holdoff_served   = 0;
  logic               rx_hold = 1'b0;

  // Clamp a glyph size to 1..MaxGlyphDim.
  function automatic int unsigned glyph_dim(logic [CfgDimW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxGlyphDim) return MaxGlyphDim;
    return v;
  endfunction

  // Saturate an origin so that origin plus a glyph column or row never wraps.
  function automatic int unsigned glyph_origin(logic [CoordW-1:0] v);
    return (v > OriginLim) ? OriginLim : v;
  endfunction

  // Walk count pixels of one coverage through the glyph rows and queue one
  // span per visible row segment; the final span of the word carries last.
  function automatic void queue_run_spans(int unsigned count, logic [CovW-1:0] cov,
                                          int unsigned w, int unsigned total);
    int unsigned ox, oy, seg, x, y, len, n;
    span_t       held;
    bit          have_held;
    ox = glyph_origin(org_x_reg);
    oy = glyph_origin(org_y_reg);
    n = 0;
    have_held = 1'b0;
    if (count > total - pixels_done) count = total - pixels_done;
    while (count > 0) begin
      seg = (count < w - column) ? count : w - column;
      x = ox + column;
      y = oy + row;
      // Compare unwrapped; keep only the part left of the screen edge.
      if (cov != 0 && x < scr_w_reg && y < scr_h_reg && n < MaxSpans) begin
        len = scr_w_reg - x;
        if (len > seg) len = seg;
        if (have_held) expected_spans.push_back(held);
        held.x    = CoordW'(x);
        held.y    = CoordW'(y);
        held.len  = LenW'(len);
        held.cov  = cov;
        held.last = 1'b0;
        have_held = 1'b1;
        n++;
      end
      column      += seg;
      pixels_done += seg;
      count       -= seg;
      if (column >= w) begin
        column = 0;
        row    = row + 1'b1;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      expected_spans.push_back(held);
    end
  endfunction

  // Advance the decode state by one word; return 0 if the word is ignored.
  function automatic bit predict_word_spans(logic [DataW-1:0] word, logic first);
    int unsigned w, h, total;
    w = glyph_dim(glyph_w_reg);
    h = glyph_dim(glyph_h_reg);
    total = w * h;
    if (first) begin
      phase       = PH_HEADER;
      block_left  = '0;
      column      = 0;
      row         = '0;
      pixels_done = 0;
    end
    if (phase == PH_DONE || pixels_done >= total) begin
      phase = PH_DONE;
      return 1'b0;
    end
    // A shrunken width pushes the column into the next row.
    if (column >= w) begin
      column = 0;
      row    = row + 1'b1;
    end
    case (phase)
      PH_HEADER: begin
        if (word[31:8] == 24'hFFFFFF) begin
          block_left = 16'(LitBase - word[7:0]);
          phase      = PH_LITERAL;
        end else begin
          block_left = word[15:0];
          phase      = PH_REPEAT;
        end
      end
      PH_LITERAL: begin
        queue_run_spans(1, word[7:0], w, total);
        if (block_left > 0) block_left--;
        if (block_left == 0) phase = PH_HEADER;
      end
      default: begin
        queue_run_spans(block_left, word[7:0], w, total);
        block_left = '0;
        phase      = PH_HEADER;
      end
    endcase
    if (pixels_done >= total) phase = PH_DONE;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random tready, forced low during a requested hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rx_hold) m_axis_tready_i <= 1'b0;
    else         m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Count out one long stall per request, independent of the sender.
  always begin
    @(posedge clk_i);
    if (holdoff_served != holdoff_requests) begin
      rx_hold = 1'b1;
      repeat (HoldOffCycles) @(posedge clk_i);
      rx_hold = 1'b0;
      holdoff_served++;
    end
  end

  // --------------------------------------------------------------------------
  // Span checker: compare each accepted span with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : span_check
    span_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.x    = m_axis_tdata_o[15:0];
      got.y    = m_axis_tdata_o[31:16];
      got.len  = m_axis_tdata_o[38:32];
      got.cov  = m_axis_tdata_o[46:39];
      got.last = m_axis_tlast_o;
      if (expected_spans.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected span: x=%0d y=%0d len=%0d cov=%0d last=%0b",
                   got.x, got.y, got.len, got.cov, got.last);
      end else begin
        want = expected_spans.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.len !== want.len ||
            got.cov !== want.cov || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("span mismatch: exp x=%0d y=%0d len=%0d cov=%0d last=%0b, got x=%0d y=%0d len=%0d cov=%0d last=%0b",
                     want.x, want.y, want.len, want.cov, want.last,
                     got.x, got.y, got.len, got.cov, got.last);
        end
      end
    end
  end

  // Stop a hung run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shared stimulus tasks
  // --------------------------------------------------------------------------
  // Offer one word, idling at random first; predict once it is accepted.
  task automatic send_word(input logic [DataW-1:0] word, input logic first);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    s_axis_tuser_i  <= first;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (predict_word_spans(word, first)) words_decoded++;
  endtask

  // Drop tvalid, wait for every pending span, then let the decoder go quiet.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_spans.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_GLYPH_WIDTH:   glyph_w_reg = value[CfgDimW-1:0];
      CFG_GLYPH_HEIGHT:  glyph_h_reg = value[CfgDimW-1:0];
      CFG_ORIGIN_X:      org_x_reg   = value;
      CFG_ORIGIN_Y:      org_y_reg   = value;
      CFG_SCREEN_WIDTH:  scr_w_reg   = value;
      CFG_SCREEN_HEIGHT: scr_h_reg   = value;
      default: ;
    endcase
  endtask

  // Write all six registers back to back while the decoder is idle.
  task automatic configure(input logic [CfgDataW-1:0] gw, input logic [CfgDataW-1:0] gh,
                           input logic [CfgDataW-1:0] ox, input logic [CfgDataW-1:0] oy,
                           input logic [CfgDataW-1:0] sw, input logic [CfgDataW-1:0] sh);
    settle();
    write_reg(CFG_GLYPH_WIDTH, gw);
    write_reg(CFG_GLYPH_HEIGHT, gh);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_SCREEN_WIDTH, sw);
    write_reg(CFG_SCREEN_HEIGHT, sh);
    cfg_we_i <= 1'b0;
  endtask

  // Pixel word with random upper bits; favor zero and full coverage.
  function automatic logic [DataW-1:0] random_pixel();
    logic [DataW-1:0] word;
    word = $urandom;
    case ($urandom_range(5))
      0:       word[7:0] = 8'h00;
      1:       word[7:0] = 8'hFF;
      default: ;
    endcase
    return word;
  endfunction

  // Send one well-formed block: a literal header and its pixels, or a repeat
  // header and its single pixel word.
  task automatic send_block(input logic first, input int unsigned total);
    int unsigned      n, i;
    logic [DataW-1:0] hdr;
    if ($urandom_range(1) == 0) begin
      case ($urandom_range(29))
        0:       n = $urandom_range(256, 1);
        1, 2:    n = $urandom_range(40, 1);
        default: n = $urandom_range(6, 1);
      endcase
      hdr = {24'hFFFFFF, 8'(LitBase - n)};
      send_word(hdr, first);
      for (i = 0; i < n; i++) send_word(random_pixel(), 1'b0);
    end else begin
      case ($urandom_range(5))
        0:       n = 0;
        1:       n = $urandom_range(3, 1);
        2, 3:    n = $urandom_range(total, 1);
        4:       n = $urandom_range(16'hFFFF);
        default: n = $urandom_range(12, 1);
      endcase
      hdr = {16'($urandom), 16'(n)};
      // Keep it a repeat header.
      if (hdr[31:8] == 24'hFFFFFF) hdr[31] = 1'b0;
      send_word(hdr, first);
      send_word(random_pixel(), 1'b0);
    end
  endtask

  // One glyph: mostly well-formed blocks until it completes, with some stray
  // words, abandoned glyphs and ignored trailing words.
  task automatic random_glyph();
    int unsigned total, blocks, pick;
    total = glyph_dim(glyph_w_reg) * glyph_dim(glyph_h_reg);
    send_block(1'b1, total);
    blocks = 0;
    while (phase != PH_DONE && blocks < 40) begin
      pick = $urandom_range(19);
      if (pick == 0) begin
        send_word($urandom, 1'b0);
      end else if (pick == 1) begin
        blocks = 40;  // abandon; the next glyph_start restarts the decoder
      end else begin
        send_block(1'b0, total);
      end
      blocks++;
    end
    if (phase == PH_DONE && $urandom_range(3) == 0) send_word($urandom, 1'b0);
  endtask

  // Random registers: mostly small visible glyphs, sometimes the extremes.
  task automatic random_config();
    logic [CfgDataW-1:0] gw, gh, ox, oy, sw, sh;
    case ($urandom_range(9))
      0:       gw = 16'd0;
      1:       gw = 16'd64;
      2:       gw = 16'hFFFF;
      3:       gw = {9'($urandom), 7'($urandom_range(12, 1))};
      default: gw = 16'($urandom_range(12, 1));
    endcase
    case ($urandom_range(9))
      0:       gh = 16'd0;
      1:       gh = 16'd64;
      2:       gh = 16'd127;
      3:       gh = {9'($urandom), 7'($urandom_range(10, 1))};
      default: gh = 16'($urandom_range(10, 1));
    endcase
    case ($urandom_range(7))
      0:       ox = 16'hFFFF;
      1:       ox = 16'($urandom_range(65535, 65400));
      2:       ox = 16'd0;
      default: ox = 16'($urandom_range(900));
    endcase
    case ($urandom_range(7))
      0:       oy = 16'hFFFF;
      1:       oy = 16'($urandom_range(65535, 65400));
      2:       oy = 16'd0;
      default: oy = 16'($urandom_range(700));
    endcase
    case ($urandom_range(7))
      0:       sw = 16'd1;
      1:       sw = 16'hFFFF;
      2:       sw = 16'($urandom_range(65535, 1));
      default: sw = 16'($urandom_range(1000, 1));
    endcase
    case ($urandom_range(7))
      0:       sh = 16'd1;
      1:       sh = 16'hFFFF;
      2:       sh = 16'($urandom_range(65535, 1));
      default: sh = 16'($urandom_range(800, 1));
    endcase
    configure(gw, gh, ox, oy, sw, sh);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset registers (8 x 16 glyph at the screen corner): both header kinds,
  // zero coverage, a zero-length repeat, a run over several rows, a run cut
  // at the glyph end and words after the end.
  task automatic test_reset_defaults();
    send_word(32'hFFFF_FFFE, 1'b1);  // literal block of two
    send_word(32'h0000_00FF, 1'b0);  // opaque pixel
    send_word(32'hFFFF_FF00, 1'b0);  // zero coverage, no span
    send_word(32'h0000_0000, 1'b0);  // repeat of zero
    send_word(32'hFFFF_FFFF, 1'b0);  // consumed, nothing
    send_word(32'h0000_0014, 1'b0);  // repeat of 20 over three rows
    send_word(32'h1234_5680, 1'b0);
    send_word(32'hFFFF_FF00, 1'b0);  // literal block of 256
    send_word(32'hDEAD_BE01, 1'b0);
    send_word(32'h0000_00FF, 1'b1);  // restart: repeat of 255, cut at 128
    send_word(32'hCAFE_F00D, 1'b0);
    send_word(32'h5555_AAAA, 1'b0);  // glyph finished, ignored
    send_word(32'hFFFF_FFFF, 1'b0);  // ignored
  endtask

  // Size clamping, origin saturation and clipping at both screen edges.
  task automatic test_clip_and_saturate();
    // Width 127 clamps to 64, height 0 to 1, origin saturates near 65535.
    configure(16'hFFFF, 16'h0000, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1);
    send_word(32'h0000_0040, 1'b1);
    send_word(32'h0000_0055, 1'b0);
    // Columns 10 and 11 visible, row 2 lands on the bottom screen edge.
    configure(16'd5, 16'd3, 16'd10, 16'd598, 16'd12, 16'd600);
    send_word(32'hFFFF_FFFB, 1'b1);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'h0000_0002, 1'b0);
    send_word(32'h0000_0003, 1'b0);
    send_word(32'h0000_0004, 1'b0);
    send_word(32'h0000_0005, 1'b0);
    send_word(32'h0000_000A, 1'b0);
    send_word(32'h7F3C_00AA, 1'b0);
  endtask

  // Resize between words of one glyph: the column wraps to the next row, and
  // a total already reached leaves later words ignored.
  task automatic test_resize_mid_glyph();
    configure(16'd8, 16'd4, 16'd100, 16'd100, 16'd800, 16'd600);
    send_word(32'h0000_0006, 1'b1);
    send_word(32'h0000_0033, 1'b0);
    configure(16'd4, 16'd4, 16'd100, 16'd100, 16'd800, 16'd600);
    send_word(32'h0000_0003, 1'b0);
    send_word(32'h0000_0044, 1'b0);
    configure(16'd4, 16'd1, 16'd100, 16'd100, 16'd800, 16'd600);
    send_word(32'h0000_0002, 1'b0);  // past the new total, ignored
    send_word(32'h0000_0002, 1'b1);
    send_word(32'h0000_0011, 1'b0);
  endtask

  // Hold the span side off for a long stretch while words keep coming so the
  // decoder backs up and stalls its input; then pause until all spans drain.
  task automatic test_output_backpressure();
    int unsigned i;
    configure(16'd64, 16'd64, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    tx_idle_pct = 0;
    holdoff_requests++;
    for (i = 0; i < 8; i++) begin
      send_word(32'h0000_012C, (i == 0));  // repeat of 300, about five rows
      send_word(random_pixel() | 32'h1, 1'b0);
    end
    settle();
  endtask

  // Random glyph streams under one idling mix.
  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input int unsigned count);
    int unsigned goal, glyphs;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    goal = words_decoded + count;
    glyphs = 0;
    while (words_decoded < goal) begin
      if (glyphs % 3 == 0) random_config();
      random_glyph();
      glyphs++;
    end
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    // Hold reset, release it on a rising edge, then run the tests in turn.
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_clip_and_saturate();
    test_resize_mid_glyph();
    test_output_backpressure();
    test_random_traffic(25, 82, 100);
    test_random_traffic(82, 25, 100);
    test_random_traffic(0, 0, 100);

    if (mismatches == 0 && expected_spans.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
